/* rtl/core/bcba_pkg.sv */
// Shared constants and types of the bitmap contiguous block allocator.
`timescale 1ns / 1ps

package bcba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF  = 32;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BSIZE_W = 17;
  localparam int unsigned BCNT_W  = 11;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

  localparam logic [DATA_W-1:0]  BASE_RST  = 32'd0;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = 17'd4096;
  localparam logic [BCNT_W-1:0]  BCNT_RST  = 11'd1024;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NOSPACE = 1'b1;

  typedef struct packed {
    logic               start;
    logic [DATA_W-1:0]  dividend;
    logic [BSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DATA_W-1:0]  quotient;
    logic [BSIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/core/bcba_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bcba_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcba_pkg::div_req_t req_i,
  output bcba_pkg::div_rsp_t rsp_o
);
  import bcba_pkg::*;

  localparam int unsigned STEPS  = DATA_W;
  localparam int unsigned STEP_W = $clog2(STEPS);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [DATA_W-1:0]  quo_q;
  logic [BSIZE_W-1:0] rem_q;
  logic [BSIZE_W-1:0] dvs_q;
  logic [BSIZE_W:0]   trial;
  logic               ge;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? BSIZE_W'(trial - {1'b0, dvs_q}) : trial[BSIZE_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/core/bitmap_contiguous_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
//
// Usage: a request enters on the in channel (valid/stall) with an action, a free
// address and a byte count; one result (granted address, status) leaves on the
// out channel. Allocate rounds the byte count up to blocks, takes the lowest run
// of free blocks below block_count, marks it used and grants
// base_address + start * block_size. Free clears the run at the given address.
// Configuration goes through the APB port (base 0x0, block size 0x4, count 0x8).
// Each request runs a divide for the block count (a free runs a second one for
// its start block); an allocation then scans bit by bit up to block_count,
// reading each bitmap word before its bits, and forms the address with a
// multiply and an add. A run to mark or clear is written by a read-modify-write
// sweep over all MAP_WORDS words; one request is worked on at a time.
// Reset: the configuration, state, word index and output valid registers reset,
// and a clearing pass zeroes the bitmap; in_stall_o stays high meanwhile.
// When the receiver stalls, the result is held in the output register; the next
// request is still taken and its result waits until the register frees up.
`timescale 1ns / 1ps

module bitmap_contiguous_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bcba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bcba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcba_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcba_pkg::DATA_W-1:0]   pwdata,
  output logic [bcba_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_action_i,
  input  logic [bcba_pkg::DATA_W-1:0]   in_free_address_i,
  input  logic [bcba_pkg::DATA_W-1:0]   in_byte_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bcba_pkg::DATA_W-1:0]   out_granted_address_o,
  output logic                          out_status_o
);
  import bcba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BI_W      = $clog2(WORD_BITS);
  localparam int unsigned CW        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PW        = DATA_W + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_DIV2 = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_MRD  = 4'd8;
  localparam logic [3:0] S_MWR  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // Configuration registers.
  logic [DATA_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [BCNT_W-1:0]  bcnt_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      bsize_q <= BSIZE_RST;
      bcnt_q  <= BCNT_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BASE_ADDRESS: base_q  <= pwdata;
        REG_BLOCK_SIZE:   bsize_q <= pwdata[BSIZE_W-1:0];
        REG_BLOCK_COUNT:  bcnt_q  <= pwdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_ADDRESS: prdata = base_q;
      REG_BLOCK_SIZE:   prdata = DATA_W'(bsize_q);
      REG_BLOCK_COUNT:  prdata = DATA_W'(bcnt_q);
      default:          prdata = '0;
    endcase
  end

  // Zero block size acts as one; count clamps to the map size.
  logic [BSIZE_W-1:0] eff_size;
  logic [CW-1:0]      eff_cnt;
  logic [DATA_W-1:0]  cnt_wide;

  assign eff_size = (bsize_q == '0) ? BSIZE_W'(1) : bsize_q;
  assign cnt_wide = (DATA_W'(bcnt_q) > DATA_W'(MAX_BLOCKS)) ? DATA_W'(MAX_BLOCKS)
                                                            : DATA_W'(bcnt_q);
  assign eff_cnt  = cnt_wide[CW-1:0];

  // Sequencer state.
  logic [3:0]          state_q, state_d;
  logic                act_q;
  logic [DATA_W-1:0]   addr_q;
  logic [DATA_W-1:0]   n_q;
  logic [CW-1:0]       idx_q;
  logic [CW-1:0]       run_q;
  logic [WI_W-1:0]     wi_q;
  logic [BI_W-1:0]     bi_q;
  logic [PW-1:0]       wbase_q;
  logic [PW-1:0]       lo_q;
  logic [PW-1:0]       hi_q;
  logic                setv_q;
  logic [DATA_W-1:0]   prod_q;
  logic [DATA_W-1:0]   res_addr_q;
  logic                res_stat_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_addr_q;
  logic                out_stat_q;

  // Bitmap memory, one word per address.
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 map_we;
  logic [WORD_BITS-1:0] map_wdata;
  logic [WORD_BITS-1:0] mask;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[wi_q] <= map_wdata;
    end
    rdata_q <= map_mem[wi_q];
  end

  // Range mask of the word at wbase_q: bits in [lo, hi) and below MAX_BLOCKS.
  always_comb begin
    logic [PW-1:0] pos;
    mask = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      pos = wbase_q + PW'(k);
      mask[k] = (pos >= lo_q) && (pos < hi_q) && (pos < PW'(MAX_BLOCKS));
    end
  end

  assign map_we    = (state_q == S_CLR) || (state_q == S_MWR);
  assign map_wdata = (state_q == S_CLR) ? '0 :
                     setv_q ? (rdata_q | mask) : (rdata_q & ~mask);

  // Shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  bcba_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  logic              in_acc;
  logic [DATA_W-1:0] n_c;
  logic [DATA_W-1:0] need_c;
  logic [CW-1:0]     start_c;
  logic              last_word;
  logic              out_free;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign n_c       = div_rsp.quotient + DATA_W'(div_rsp.remainder != '0);
  assign need_c    = (n_q == '0) ? DATA_W'(1) : n_q;
  assign start_c   = CW'(idx_q + CW'(1) - need_c[CW-1:0]);
  assign last_word = (wi_q == WI_W'(MAP_WORDS - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = in_byte_count_i;
    div_req.divisor  = eff_size;
    state_d          = state_q;
    if (state_q == S_IDLE && in_acc) begin
      div_req.start = 1'b1;
    end
    if (state_q == S_DIV1 && div_rsp.done && act_q == ACT_FREE) begin
      div_req.start    = 1'b1;
      div_req.dividend = addr_q - base_q;
    end
    unique case (state_q)
      S_CLR:  if (last_word) state_d = S_IDLE;
      S_IDLE: if (in_acc) state_d = S_DIV1;
      S_DIV1: begin
        if (div_rsp.done) begin
          if (act_q == ACT_FREE) begin
            state_d = S_DIV2;
          end else if (n_c > DATA_W'(eff_cnt) || eff_cnt == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_DIV2: if (div_rsp.done) state_d = S_MRD;
      S_SRD:  state_d = S_SCAN;
      S_SCAN: begin
        if (idx_q == eff_cnt) begin
          state_d = S_DONE;
        end else if (!rdata_q[bi_q] && (DATA_W'(run_q) + DATA_W'(1) == need_c)) begin
          state_d = S_MUL;
        end else if (bi_q == BI_W'(WORD_BITS - 1)) begin
          state_d = S_SRD;
        end
      end
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = (n_q == '0) ? S_DONE : S_MRD;
      S_MRD:  state_d = S_MWR;
      // Read the next word before each write; leave after the last one.
      S_MWR:  state_d = last_word ? S_DONE : S_MRD;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      wi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      priority if (state_q == S_CLR) begin
        wi_q <= last_word ? '0 : wi_q + WI_W'(1);
      end else if (state_q == S_SCAN && state_d == S_SRD) begin
        wi_q <= wi_q + WI_W'(1);
      end else if (state_q == S_MWR) begin
        wi_q <= wi_q + WI_W'(1);
      end else if (state_d == S_MRD && state_q != S_MWR) begin
        wi_q <= '0;
      end else if (state_q == S_DIV1 && state_d == S_SRD) begin
        wi_q <= '0;
      end else begin
        wi_q <= wi_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      act_q      <= in_action_i;
      addr_q     <= in_free_address_i;
      res_addr_q <= '0;
      res_stat_q <= ST_DONE;
    end
    if (state_q == S_DIV1 && div_rsp.done) begin
      n_q     <= n_c;
      idx_q   <= '0;
      run_q   <= '0;
      bi_q    <= '0;
      if (act_q == ACT_ALLOC && state_d == S_DONE) begin
        res_stat_q <= ST_NOSPACE;
      end
    end
    if (state_q == S_DIV2 && div_rsp.done) begin
      lo_q    <= PW'(div_rsp.quotient);
      hi_q    <= PW'(div_rsp.quotient) + PW'(n_q);
      setv_q  <= 1'b0;
      wbase_q <= '0;
    end
    if (state_q == S_SCAN) begin
      if (idx_q == eff_cnt) begin
        res_stat_q <= ST_NOSPACE;
      end else if (state_d == S_MUL) begin
        lo_q   <= PW'(start_c);
        hi_q   <= PW'(start_c) + PW'(n_q);
        setv_q <= 1'b1;
      end else begin
        run_q <= rdata_q[bi_q] ? '0 : run_q + CW'(1);
        idx_q <= idx_q + CW'(1);
        bi_q  <= (bi_q == BI_W'(WORD_BITS - 1)) ? '0 : bi_q + BI_W'(1);
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= lo_q[DATA_W-1:0] * DATA_W'(eff_size);
    end
    if (state_q == S_ADD) begin
      res_addr_q <= base_q + prod_q;
      wbase_q    <= '0;
    end
    if (state_q == S_MWR) begin
      wbase_q <= wbase_q + PW'(WORD_BITS);
    end
    if (state_q == S_DONE && out_free) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_granted_address_o = out_addr_q;
  assign out_status_o          = out_stat_q;

`ifndef SYNTHESIS
  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o |-> out_granted_address_o == '0)
    else $error("failed request carries a nonzero address");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block took a request without going busy");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= eff_cnt)
    else $error("scan ran past block count");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a divide step");
`endif

endmodule
